FILE: src/bres_pkg.sv
package bres_pkg;

   localparam int COORD_BITS = 12;
   localparam int COLOR_BITS = 32;
   // The error term stays within (-major_delta, 3*major_delta].
   localparam int ERR_BITS = COORD_BITS + 3;

   localparam int REQ_FIELD_BITS = 4 * COORD_BITS + COLOR_BITS;
   localparam int REQ_DATA_BITS = ((REQ_FIELD_BITS + 7) / 8) * 8;
   localparam int RSP_FIELD_BITS = 2 * COORD_BITS + COLOR_BITS;
   localparam int RSP_DATA_BITS = ((RSP_FIELD_BITS + 7) / 8) * 8;

   // Bit offsets of the request fields inside req_tdata.
   localparam int FIRST_X_LSB = 0;
   localparam int FIRST_Y_LSB = COORD_BITS;
   localparam int SECOND_X_LSB = 2 * COORD_BITS;
   localparam int SECOND_Y_LSB = 3 * COORD_BITS;
   localparam int COLOR_LSB = 4 * COORD_BITS;

   typedef logic [COORD_BITS-1:0] coord_type;
   typedef logic [COLOR_BITS-1:0] color_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      coord_type first_x;
      coord_type first_y;
      coord_type second_x;
      coord_type second_y;
      color_type color;
   } request_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      color_type pixel_color;
      logic      last_pixel;
   } pixel_type;

   typedef struct packed {
      logic fire;
      logic drawing;
   } core_status_type;

endpackage

FILE: src/bres_in_reg.sv
module bres_in_reg (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [bres_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  take,
   output logic                  item_valid,
   output bres_pkg::request_type item
);

   logic                  valid_ff;
   logic                  valid_in;
   bres_pkg::request_type item_ff;

   // The register accepts a new request whenever it is empty or its content leaves now.
   assign req_tready = !valid_ff || take;
   assign valid_in = req_tready ? req_tvalid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         item_ff.kind     <= bres_pkg::kind_type'(req_tuser);
         item_ff.first_x  <= req_tdata[bres_pkg::FIRST_X_LSB +: bres_pkg::COORD_BITS];
         item_ff.first_y  <= req_tdata[bres_pkg::FIRST_Y_LSB +: bres_pkg::COORD_BITS];
         item_ff.second_x <= req_tdata[bres_pkg::SECOND_X_LSB +: bres_pkg::COORD_BITS];
         item_ff.second_y <= req_tdata[bres_pkg::SECOND_Y_LSB +: bres_pkg::COORD_BITS];
         item_ff.color    <= req_tdata[bres_pkg::COLOR_LSB +: bres_pkg::COLOR_BITS];
      end
   end

   assign item_valid = valid_ff;
   assign item = item_ff;

endmodule

FILE: src/bres_core.sv
module bres_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      item_valid,
   input  bres_pkg::request_type     item,
   input  logic                      out_space,
   output logic                      take,
   output logic                      pixel_valid,
   output bres_pkg::pixel_type       pixel,
   output bres_pkg::core_status_type status
);

   localparam int CB = bres_pkg::COORD_BITS;
   localparam int EB = bres_pkg::ERR_BITS;

   logic                    drawing_ff;
   logic                    drawing_in;
   logic [CB-1:0]           major_pos_ff;
   logic [CB-1:0]           major_end_ff;
   logic [CB-1:0]           minor_pos_ff;
   logic signed [EB-1:0]    error_acc_ff;
   logic [CB-1:0]           major_delta_ff;
   logic [CB:0]             minor_twice_ff;
   logic                    minor_up_ff;
   logic                    axes_swapped_ff;
   bres_pkg::color_type     line_color_ff;

   // Start setup.
   logic [CB-1:0] abs_dx;
   logic [CB-1:0] abs_dy;
   logic          steep;
   logic [CB-1:0] maj_a;
   logic [CB-1:0] maj_b;
   logic [CB-1:0] min_a;
   logic [CB-1:0] min_b;
   logic          flip;
   logic [CB-1:0] maj_lo;
   logic [CB-1:0] maj_hi;
   logic [CB-1:0] min_lo;
   logic [CB-1:0] min_hi;
   logic [CB-1:0] abs_dmin;

   // Step datapath.
   logic                 last;
   logic signed [EB-1:0] err_sum;
   logic signed [EB-1:0] delta_ext;
   logic signed [EB-1:0] delta_twice;
   logic                 over;
   logic                 is_start;
   logic                 is_step;

   assign take = item_valid && out_space;
   assign is_start = take && (item.kind == bres_pkg::KIND_START);
   assign is_step = take && (item.kind == bres_pkg::KIND_STEP) && drawing_ff;

   assign abs_dx = (item.first_x > item.second_x) ? item.first_x - item.second_x
                                                  : item.second_x - item.first_x;
   assign abs_dy = (item.first_y > item.second_y) ? item.first_y - item.second_y
                                                  : item.second_y - item.first_y;
   // A tie between the deltas leaves x as the major axis.
   assign steep = abs_dx < abs_dy;
   assign maj_a = steep ? item.first_y : item.first_x;
   assign min_a = steep ? item.first_x : item.first_y;
   assign maj_b = steep ? item.second_y : item.second_x;
   assign min_b = steep ? item.second_x : item.second_y;
   assign flip = maj_a > maj_b;
   assign maj_lo = flip ? maj_b : maj_a;
   assign maj_hi = flip ? maj_a : maj_b;
   assign min_lo = flip ? min_b : min_a;
   assign min_hi = flip ? min_a : min_b;
   assign abs_dmin = (min_lo > min_hi) ? min_lo - min_hi : min_hi - min_lo;

   assign last = major_pos_ff == major_end_ff;
   assign err_sum = error_acc_ff + $signed({{(EB-CB-1){1'b0}}, minor_twice_ff});
   assign delta_ext = $signed({{(EB-CB){1'b0}}, major_delta_ff});
   assign delta_twice = $signed({{(EB-CB-1){1'b0}}, major_delta_ff, 1'b0});
   assign over = err_sum > delta_ext;

   always_comb begin
      drawing_in = drawing_ff;
      if (is_start) begin
         drawing_in = 1'b1;
      end else if (is_step && last) begin
         drawing_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         drawing_ff <= 1'b0;
      end else begin
         drawing_ff <= drawing_in;
      end
   end

   always_ff @(posedge clock) begin
      if (is_start) begin
         major_pos_ff    <= maj_lo;
         major_end_ff    <= maj_hi;
         minor_pos_ff    <= min_lo;
         error_acc_ff    <= '0;
         major_delta_ff  <= maj_hi - maj_lo;
         minor_twice_ff  <= {abs_dmin, 1'b0};
         minor_up_ff     <= min_hi > min_lo;
         axes_swapped_ff <= steep;
         line_color_ff   <= item.color;
      end else if (is_step && !last) begin
         major_pos_ff <= major_pos_ff + 1'b1;
         if (over) begin
            minor_pos_ff <= minor_up_ff ? minor_pos_ff + 1'b1 : minor_pos_ff - 1'b1;
            error_acc_ff <= err_sum - delta_twice;
         end else begin
            error_acc_ff <= err_sum;
         end
      end
   end

   assign pixel_valid = is_step;
   assign pixel.pixel_x = axes_swapped_ff ? minor_pos_ff : major_pos_ff;
   assign pixel.pixel_y = axes_swapped_ff ? major_pos_ff : minor_pos_ff;
   assign pixel.pixel_color = line_color_ff;
   assign pixel.last_pixel = last;

   assign status.fire = is_step;
   assign status.drawing = drawing_ff;

endmodule

FILE: src/bres_out_reg.sv
module bres_out_reg (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 load,
   input  bres_pkg::pixel_type  pixel,
   output logic                 space,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [bres_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   logic                valid_ff;
   logic                valid_in;
   bres_pkg::pixel_type pixel_ff;

   // The register frees up in the same cycle that the sink takes its pixel.
   assign space = !valid_ff || rsp_tready;
   assign valid_in = load || (valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pixel_ff <= pixel;
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = bres_pkg::RSP_DATA_BITS'({pixel_ff.pixel_color, pixel_ff.pixel_y,
                                                pixel_ff.pixel_x});
   assign rsp_tlast = pixel_ff.last_pixel;

endmodule

FILE: src/bresenham_line_pixel_generator.sv
// Bresenham line pixel generator.
// Path: a step request is accepted into the input register, and its pixel is registered
// in the output register, which drives rsp, once that register has room. Throughput: one
// request per cycle while the output register has room; each step is one add, compare and
// subtract between the request and pixel registers. A pixel left waiting stalls the core.
// Reset: synchronous, active high; clears both stage valids and leaves the block idle.
module bresenham_line_pixel_generator (
   input  logic clock,
   input  logic reset,
   // Request channel.
   input  logic req_tvalid,
   output logic req_tready,
   // req_tdata, lowest bit up: first_x, first_y, second_x, second_y, color.
   input  logic [bres_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser: kind (0 starts a line, 1 asks for the next pixel).
   input  logic req_tuser,
   // Pixel channel.
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rsp_tdata, lowest bit up: pixel_x, pixel_y, pixel_color.
   output logic [bres_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // rsp_tlast: last_pixel, high on the final pixel of a line.
   output logic rsp_tlast
);

   // A request first lands in the input register. From there the core either loads a new
   // line (start request, no pixel), drops it (step while idle), or emits one pixel into
   // the output register and advances the line state. The core moves a request only when
   // the output register has room, so a stalled sink holds the input register. While a
   // finished pixel waits to be taken, the input register still absorbs one more request,
   // and after that the request channel stalls until the sink takes the pixel.

   logic                      item_valid;
   bres_pkg::request_type     item;
   logic                      take;
   logic                      out_space;
   logic                      pixel_valid;
   bres_pkg::pixel_type       pixel;
   bres_pkg::core_status_type status;

   bres_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   bres_core u_core (
      .clock       (clock),
      .reset       (reset),
      .item_valid  (item_valid),
      .item        (item),
      .out_space   (out_space),
      .take        (take),
      .pixel_valid (pixel_valid),
      .pixel       (pixel),
      .status      (status)
   );

   bres_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (pixel_valid),
      .pixel      (pixel),
      .space      (out_space),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef ASSERT_OFF
   // A pixel is produced only while a line is being drawn.
   a_pixel_needs_line : assert property (@(posedge clock) disable iff (reset)
      status.fire |-> status.drawing)
      else $error("pixel produced while idle");

   // The final pixel of a line returns the block to idle.
   a_last_ends_line : assert property (@(posedge clock) disable iff (reset)
      status.fire && pixel.last_pixel |=> !status.drawing)
      else $error("line still active after its last pixel");

   // A start request always leaves a line in progress.
   a_start_begins_line : assert property (@(posedge clock) disable iff (reset)
      take && item.kind == bres_pkg::KIND_START |=> status.drawing)
      else $error("start request did not begin a line");

   // A pixel enters the output register only when it has room.
   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      pixel_valid |-> out_space)
      else $error("pixel loaded over a waiting pixel");
`endif

endmodule

FILE: test/bresenham_pixel_checker.sv
module bresenham_pixel_checker (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   input  logic req_tready,
   // req_tdata, lowest bit up: first_x, first_y, second_x, second_y, color.
   input  logic [bres_pkg::REQ_DATA_BITS-1:0] req_tdata,
   // req_tuser: kind.
   input  logic req_tuser,
   input  logic rsp_tvalid,
   input  logic rsp_tready,
   // rsp_tdata, lowest bit up: pixel_x, pixel_y, pixel_color.
   input  logic [bres_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   input  logic rsp_tlast,
   output int mismatch_count,
   output int pixels_pending
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int SPAN_BITS = bres_pkg::COORD_BITS + 1;

   // Line state, kept at the widths the block uses.
   logic                                 line_active;
   bres_pkg::coord_type                  major_at;
   bres_pkg::coord_type                  major_stop;
   bres_pkg::coord_type                  minor_at;
   logic signed [bres_pkg::ERR_BITS-1:0] slope_error;
   bres_pkg::coord_type                  major_span;
   logic [SPAN_BITS-1:0]                 minor_span_x2;
   logic                                 minor_rising;
   logic                                 steep_line;
   bres_pkg::color_type                  line_rgba;

   bres_pkg::pixel_type expected_pixels[$];

   task automatic load_line(input bres_pkg::coord_type ax_in, input bres_pkg::coord_type ay_in,
                            input bres_pkg::coord_type bx_in, input bres_pkg::coord_type by_in,
                            input bres_pkg::color_type rgba);
      int ax, ay, bx, by, t, dx, dy;
      logic steep;
      ax = int'(ax_in);
      ay = int'(ay_in);
      bx = int'(bx_in);
      by = int'(by_in);
      dx = ax > bx ? ax - bx : bx - ax;
      dy = ay > by ? ay - by : by - ay;
      // A tie between the deltas keeps x as the major axis.
      steep = dx < dy;
      if (steep) begin
         t = ax; ax = ay; ay = t;
         t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
         t = ax; ax = bx; bx = t;
         t = ay; ay = by; by = t;
      end
      major_at      = bres_pkg::coord_type'(ax);
      major_stop    = bres_pkg::coord_type'(bx);
      minor_at      = bres_pkg::coord_type'(ay);
      major_span    = bres_pkg::coord_type'(bx - ax);
      minor_span_x2 = SPAN_BITS'(2 * (ay > by ? ay - by : by - ay));
      minor_rising  = by > ay;
      steep_line    = steep;
      slope_error   = '0;
      line_rgba     = rgba;
      line_active   = 1'b1;
   endtask

   task automatic advance_line();
      bres_pkg::pixel_type px;
      int err;
      if (line_active) begin
         px.pixel_x     = steep_line ? minor_at : major_at;
         px.pixel_y     = steep_line ? major_at : minor_at;
         px.pixel_color = line_rgba;
         px.last_pixel  = (major_at == major_stop);
         expected_pixels.push_back(px);
         if (px.last_pixel) begin
            line_active = 1'b0;
         end else begin
            err = int'(slope_error) + int'(minor_span_x2);
            if (err > int'(major_span)) begin
               minor_at = minor_rising ? minor_at + 1'b1 : minor_at - 1'b1;
               err = err - 2 * int'(major_span);
            end
            slope_error = bres_pkg::ERR_BITS'(err);
            major_at    = major_at + 1'b1;
         end
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   task automatic check_pixel();
      bres_pkg::pixel_type want;
      if (expected_pixels.size() == 0) begin
         $display("%0t: pixel with none expected, expected nothing, actual x=%0d y=%0d",
                  $time, rsp_tdata[0 +: bres_pkg::COORD_BITS],
                  rsp_tdata[bres_pkg::COORD_BITS +: bres_pkg::COORD_BITS]);
         mismatch_count++;
      end else begin
         want = expected_pixels.pop_front();
         check_field("pixel_x", 32'(want.pixel_x), 32'(rsp_tdata[0 +: bres_pkg::COORD_BITS]));
         check_field("pixel_y", 32'(want.pixel_y),
                     32'(rsp_tdata[bres_pkg::COORD_BITS +: bres_pkg::COORD_BITS]));
         check_field("pixel_color", want.pixel_color,
                     rsp_tdata[2*bres_pkg::COORD_BITS +: bres_pkg::COLOR_BITS]);
         check_field("last_pixel", 32'(want.last_pixel), 32'(rsp_tlast));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         line_active    = 1'b0;
         mismatch_count = 0;
         expected_pixels.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            if (bres_pkg::kind_type'(req_tuser) == bres_pkg::KIND_START) begin
               load_line(req_tdata[bres_pkg::FIRST_X_LSB +: bres_pkg::COORD_BITS],
                         req_tdata[bres_pkg::FIRST_Y_LSB +: bres_pkg::COORD_BITS],
                         req_tdata[bres_pkg::SECOND_X_LSB +: bres_pkg::COORD_BITS],
                         req_tdata[bres_pkg::SECOND_Y_LSB +: bres_pkg::COORD_BITS],
                         req_tdata[bres_pkg::COLOR_LSB +: bres_pkg::COLOR_BITS]);
            end else begin
               advance_line();
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            check_pixel();
         end
      end
      pixels_pending = expected_pixels.size();
   end

endmodule

FILE: test/tb_bresenham_line_pixel_generator.sv
module tb_bresenham_line_pixel_generator;
   timeunit 1ns;
   timeprecision 1ps;

   // Number of cycles the pixel side refuses data during the back-pressure test.
   localparam int HOLD_OFF_CYCLES = 300;
   // Rough size of the whole run, in requests.
   localparam int REQUEST_TARGET = 1800;

   logic clock = 1'b0;
   logic reset = 1'b1;

   // All block inputs start at known values.
   logic                               req_tvalid = 1'b0;
   logic                               req_tready;
   logic [bres_pkg::REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                               req_tuser = 1'b0;
   logic                               rsp_tvalid;
   logic                               rsp_tready = 1'b0;
   logic [bres_pkg::RSP_DATA_BITS-1:0] rsp_tdata;
   logic                               rsp_tlast;

   int mismatch_count;
   int pixels_pending;

   // Knobs shared between the request side and the pixel side.
   bit sender_idle_on = 1'b1;
   bit ready_idle_on  = 1'b1;
   bit hold_off_armed = 1'b0;
   bit hold_off_done  = 1'b0;
   int hold_off_count = 0;
   int requests_sent  = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   bresenham_line_pixel_generator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   // The checker predicts every pixel from the accepted requests and compares
   // it against what comes out of the pixel channel.
   bresenham_pixel_checker pixel_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .pixels_pending (pixels_pending)
   );

   // Pixel side. It normally drops ready at random, about 15 percent of the time. Once
   // the back-pressure test is armed it refuses data for a long stretch, counted
   // here, so that the block fills up and has to stall its request channel.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_armed && !hold_off_done) begin
         rsp_tready <= 1'b0;
         hold_off_count++;
         if (hold_off_count >= HOLD_OFF_CYCLES) begin
            hold_off_done = 1'b1;
         end
      end else begin
         rsp_tready <= !ready_idle_on || ($urandom_range(99) >= 15);
      end
   end

   // Offers one request and returns at the edge where it is accepted. Valid is
   // left high afterwards, so back-to-back requests never lower and raise it in
   // the same step; anyone who stops sending must lower it first.
   task automatic offer_request(input bres_pkg::kind_type kind,
                                input bres_pkg::coord_type fx, input bres_pkg::coord_type fy,
                                input bres_pkg::coord_type sx, input bres_pkg::coord_type sy,
                                input bres_pkg::color_type rgba);
      logic [bres_pkg::REQ_DATA_BITS-1:0] word;
      word = '0;
      word[bres_pkg::FIRST_X_LSB +: bres_pkg::COORD_BITS]  = fx;
      word[bres_pkg::FIRST_Y_LSB +: bres_pkg::COORD_BITS]  = fy;
      word[bres_pkg::SECOND_X_LSB +: bres_pkg::COORD_BITS] = sx;
      word[bres_pkg::SECOND_Y_LSB +: bres_pkg::COORD_BITS] = sy;
      word[bres_pkg::COLOR_LSB +: bres_pkg::COLOR_BITS]    = rgba;
      if (sender_idle_on && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= word;
      req_tuser  <= kind;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      requests_sent++;
   endtask

   // Starts a line and then asks for as many pixels as it has plus extra.
   // A negative extra leaves the line unfinished, so the next start abandons it;
   // a positive one sends step requests to an idle block, which must ignore them.
   task automatic draw_line(input bres_pkg::coord_type fx, input bres_pkg::coord_type fy,
                            input bres_pkg::coord_type sx, input bres_pkg::coord_type sy,
                            input bres_pkg::color_type rgba, input int extra);
      int dx, dy, steps;
      dx = int'(fx) > int'(sx) ? int'(fx) - int'(sx) : int'(sx) - int'(fx);
      dy = int'(fy) > int'(sy) ? int'(fy) - int'(sy) : int'(sy) - int'(fy);
      steps = (dx > dy ? dx : dy) + 1 + extra;
      offer_request(bres_pkg::KIND_START, fx, fy, sx, sy, rgba);
      for (int i = 0; i < steps; i++) begin
         // Coordinates and color of a step request are don't-care, so they are noise.
         offer_request(bres_pkg::KIND_STEP, bres_pkg::coord_type'($urandom),
                       bres_pkg::coord_type'($urandom), bres_pkg::coord_type'($urandom),
                       bres_pkg::coord_type'($urandom), $urandom);
      end
   endtask

   // Lowers valid and waits until every predicted pixel has come out.
   task automatic drain_pixels();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pixels_pending != 0) @(posedge clock);
   endtask

   // A coordinate within reach of a base, clamped to the coordinate range.
   function automatic bres_pkg::coord_type near(input bres_pkg::coord_type base,
                                                input int reach);
      int v;
      v = int'(base) + int'($urandom_range(2 * reach)) - reach;
      if (v < 0) begin
         v = 0;
      end else if (v > (1 << bres_pkg::COORD_BITS) - 1) begin
         v = (1 << bres_pkg::COORD_BITS) - 1;
      end
      return bres_pkg::coord_type'(v);
   endfunction

   initial begin
      bres_pkg::coord_type fx, fy, sx, sy;
      int choice;
      int reach;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part.
      // A step request right after reset finds the block idle and yields nothing.
      offer_request(bres_pkg::KIND_STEP, 12'hFFF, 12'hFFF, 12'hFFF, 12'hFFF, 32'hFFFF_FFFF);
      // A single-point line gives one pixel flagged last; the extra step is ignored.
      draw_line(12'd5, 12'd7, 12'd5, 12'd7, 32'h0000_0000, 1);
      // A line at the top corner, given right to left, so the endpoints are swapped.
      draw_line(12'd4095, 12'd4095, 12'd4093, 12'd4094, 32'hFFFF_FFFF, 0);
      // A horizontal line at the edge: the minor coordinate never moves.
      draw_line(12'd0, 12'd4095, 12'd3, 12'd4095, 32'hA5A5_5A5A, 0);
      // A steep line, which runs along y and swaps the axes back on output.
      draw_line(12'd10, 12'd0, 12'd12, 12'd5, 32'h1234_5678, 0);
      // Equal deltas keep x as the major axis; this one runs downward in y.
      draw_line(12'd100, 12'd100, 12'd103, 12'd97, 32'h8000_0001, 0);
      drain_pixels();

      // Back pressure: a full-width line is started and stepped while the pixel
      // side refuses data, so the block has to stall its request channel. The
      // line is then abandoned by the steep full-height line, which is itself
      // abandoned by the random part.
      hold_off_armed = 1'b1;
      draw_line(12'd0, 12'd17, 12'd4095, 12'd3000, $urandom, -4016);
      draw_line(12'd5, 12'd0, 12'd4000, 12'd4095, $urandom, -4076);

      // Random part. Most of it is whole lines with random endpoints; the rest
      // is loose requests and lines cut short by the next start.
      while (requests_sent < REQUEST_TARGET) begin
         // A stretch in the middle runs with no idling on either side.
         sender_idle_on = !(requests_sent >= 800 && requests_sent < 1100);
         ready_idle_on  = sender_idle_on;

         // Now and then the sender stops until every pixel has come out.
         if ($urandom_range(99) < 2) begin
            drain_pixels();
         end

         fx = $urandom_range(9) == 0 ? ($urandom_range(1) ? 12'd4095 : 12'd0)
                                     : bres_pkg::coord_type'($urandom);
         fy = $urandom_range(9) == 0 ? ($urandom_range(1) ? 12'd4095 : 12'd0)
                                     : bres_pkg::coord_type'($urandom);
         reach = $urandom_range(19) == 0 ? 120 : int'($urandom_range(20));
         sx = near(fx, reach);
         sy = near(fy, reach);
         choice = int'($urandom_range(99));
         if (choice < 85) begin
            draw_line(fx, fy, sx, sy, $urandom, int'($urandom_range(4)) - 2);
         end else if (choice < 93) begin
            offer_request(bres_pkg::kind_type'($urandom_range(1)),
                          bres_pkg::coord_type'($urandom), bres_pkg::coord_type'($urandom),
                          bres_pkg::coord_type'($urandom), bres_pkg::coord_type'($urandom),
                          $urandom);
         end else begin
            draw_line(fx, fy, sx, sy, $urandom, -int'($urandom_range(6, 1)));
         end
      end

      drain_pixels();
      // The block can still be working on nothing visible; give it a few cycles
      // so a stray extra pixel would be caught.
      repeat (20) @(posedge clock);

      if (mismatch_count == 0 && pixels_pending == 0) begin
         $display("tb_bresenham_line_pixel_generator OK");
      end else begin
         $display("tb_bresenham_line_pixel_generator NOT OK");
      end
      $finish;
   end

   // Guard against a hang: far longer than the slowest correct run needs.
   initial begin
      #400_000;
      $display("tb_bresenham_line_pixel_generator NOT OK");
      $finish;
   end

endmodule

FILE: sim.f
src/bres_pkg.sv
src/bres_in_reg.sv
src/bres_core.sv
src/bres_out_reg.sv
src/bresenham_line_pixel_generator.sv
test/bresenham_pixel_checker.sv
test/tb_bresenham_line_pixel_generator.sv
